// ----- design/spok_pkg.sv -----
// Shared constants, types and helpers for the spiral-order element lookup block.
// Used by the channel interfaces, the position walker and the top level.
`timescale 1ns / 1ps

package spok_pkg;

    // Matrix geometry and data width
    localparam int MAX_DIM    = 32;
    localparam int DATA_WIDTH = 32;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CNT_W      = DIM_W + 1;
    localparam int ADDR_W     = 2 * DIM_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int POS_W      = 11;
    localparam int AREA_W     = 2 * CNT_W;

    // Configuration port
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    // Request commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Start request for the position walker
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
        logic [POS_W-1:0] pos;
    } t_loc_req;

    // Located element, with a one-cycle done pulse
    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } t_loc_rsp;

    // A dimension above the maximum saturates to the maximum.
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (CNT_W'(v) > CNT_W'(MAX_DIM)) begin
            res = CNT_W'(MAX_DIM);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

// ----- design/spok_in_if.sv -----
// Input channel interface: valid/ready handshake with the request payload.
// Depends on spok_pkg for field widths.
`timescale 1ns / 1ps

interface spok_in_if import spok_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [DIM_W-1:0]      row_index;
    logic [DIM_W-1:0]      column_index;
    logic [DATA_WIDTH-1:0] element_value;
    logic [POS_W-1:0]      spiral_position;

    modport source (
        output valid, command, row_index, column_index, element_value, spiral_position,
        input  ready
    );

    modport sink (
        input  valid, command, row_index, column_index, element_value, spiral_position,
        output ready
    );

endinterface

// ----- design/spok_out_if.sv -----
// Output channel interface: valid/ready handshake with the result payload.
// Depends on spok_pkg for field widths.
`timescale 1ns / 1ps

interface spok_out_if import spok_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] found_value;
    logic                  out_of_range;

    modport source (
        output valid, found_value, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, found_value, out_of_range,
        output ready
    );

endinterface

// ----- design/spok_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module spok_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/spok_locate.sv -----
// Spiral position walker: steps one edge of the spiral per cycle through a
// shared compare/subtract unit until the offset falls on an edge. Uses spok_pkg.
`timescale 1ns / 1ps

module spok_locate import spok_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_loc_req i_req,
    output t_loc_rsp o_rsp
);

    typedef enum logic [3:0] {
        PH_TOP    = 4'b0001,
        PH_RIGHT  = 4'b0010,
        PH_BOTTOM = 4'b0100,
        PH_LEFT   = 4'b1000
    } t_phase;

    logic             r_busy, n_busy;
    t_phase           r_phase, n_phase;
    logic [DIM_W-1:0] r_top, n_top;
    logic [DIM_W-1:0] r_bot, n_bot;
    logic [DIM_W-1:0] r_left, n_left;
    logic [DIM_W-1:0] r_right, n_right;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_done, n_done;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;

    logic [CNT_W-1:0] span_h;
    logic [CNT_W-1:0] span_v;
    logic [CNT_W-1:0] edge_len;
    logic             hit;
    logic [DIM_W-1:0] off;
    logic [DIM_W-1:0] hit_row;
    logic [DIM_W-1:0] hit_col;

    // Edge lengths of the current ring
    assign span_h = CNT_W'(r_right) - CNT_W'(r_left);
    assign span_v = CNT_W'(r_bot) - CNT_W'(r_top);

    // Shared unit: pick the edge length and where an offset lands on that edge.
    always_comb begin
        edge_len = '0;
        hit_row  = r_top;
        hit_col  = r_left;
        off      = r_pos[DIM_W-1:0];
        case (r_phase)
            PH_TOP: begin
                edge_len = span_h + CNT_W'(1);
                hit_row  = r_top;
                hit_col  = r_left + off;
            end
            PH_RIGHT: begin
                edge_len = span_v;
                hit_row  = r_top + DIM_W'(1) + off;
                hit_col  = r_right;
            end
            PH_BOTTOM: begin
                edge_len = (r_top < r_bot) ? span_h : '0;
                hit_row  = r_bot;
                hit_col  = r_right - DIM_W'(1) - off;
            end
            PH_LEFT: begin
                edge_len = (r_left < r_right && r_top < r_bot) ? span_v - CNT_W'(1) : '0;
                hit_row  = r_bot - DIM_W'(1) - off;
                hit_col  = r_left;
            end
            default: begin
                edge_len = '0;
            end
        endcase
    end

    assign hit = r_pos < POS_W'(edge_len);

    // Sequencer: load a request, then one edge per cycle.
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_top   = r_top;
        n_bot   = r_bot;
        n_left  = r_left;
        n_right = r_right;
        n_pos   = r_pos;
        n_done  = 1'b0;
        n_row   = r_row;
        n_col   = r_col;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_phase = PH_TOP;
            n_top   = '0;
            n_left  = '0;
            n_bot   = DIM_W'(i_req.rows - CNT_W'(1));
            n_right = DIM_W'(i_req.cols - CNT_W'(1));
            n_pos   = i_req.pos;
        end else if (r_busy) begin
            if (hit) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_row  = hit_row;
                n_col  = hit_col;
            end else begin
                n_pos = r_pos - POS_W'(edge_len);
                case (r_phase)
                    PH_TOP:    n_phase = PH_RIGHT;
                    PH_RIGHT:  n_phase = PH_BOTTOM;
                    PH_BOTTOM: n_phase = PH_LEFT;
                    PH_LEFT: begin
                        // Move in to the next inner ring.
                        n_phase = PH_TOP;
                        n_top   = r_top + DIM_W'(1);
                        n_left  = r_left + DIM_W'(1);
                        n_bot   = r_bot - DIM_W'(1);
                        n_right = r_right - DIM_W'(1);
                    end
                    default:   n_phase = PH_TOP;
                endcase
            end
        end
    end

    // Control state is reset; ring bounds and offset are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_TOP;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top   <= n_top;
        r_bot   <= n_bot;
        r_left  <= n_left;
        r_right <= n_right;
        r_pos   <= n_pos;
        r_row   <= n_row;
        r_col   <= n_col;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.row  = r_row;
    assign o_rsp.col  = r_col;

endmodule

// ----- design/spiral_order_kth_element.sv -----
// A write goes straight into the matrix. A query is accepted, then the walker steps
// one spiral edge at a time until the position falls on an edge; the element is read from
// the matrix into the output register once it is free. Out-of-range queries skip both.
// Requests wait until a query's result is loaded; writes go one per cycle while idle.
// Reset: synchronous, active low; clears control state and sets both dimensions to 32.
// The matrix contents are not cleared and are undefined until written.
`timescale 1ns / 1ps

module spiral_order_kth_element import spok_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spok_in_if.sink              i_in,
    spok_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_row_count;
    logic [CFG_W-1:0]      r_col_count;
    logic                  r_err, n_err;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_found, n_found;
    logic                  r_oor, n_oor;

    logic [CNT_W-1:0]      rows_c;
    logic [CNT_W-1:0]      cols_c;
    logic [AREA_W-1:0]     area;
    logic                  pos_bad;
    logic                  accept;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  out_free;
    t_loc_req              loc_req;
    t_loc_rsp              loc_rsp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_W'(MAX_DIM);
            r_col_count <= CFG_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_COUNT:    r_row_count <= i_cfg_data;
                REG_COLUMN_COUNT: r_col_count <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Range check of the queried position against the matrix area
    assign rows_c  = clamp_dim(r_row_count);
    assign cols_c  = clamp_dim(r_col_count);
    assign area    = AREA_W'(rows_c) * AREA_W'(cols_c);
    assign pos_bad = (i_in.spiral_position == '0) || (AREA_W'(i_in.spiral_position) > area);

    // Request handshake: one request at a time.
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Element writes go straight to the matrix store.
    assign ram_we    = accept && (i_in.command == CMD_WRITE);
    assign ram_waddr = {i_in.row_index, i_in.column_index};

    // Start the walker for an in-range query.
    assign loc_req.start = accept && (i_in.command == CMD_QUERY) && !pos_bad;
    assign loc_req.rows  = rows_c;
    assign loc_req.cols  = cols_c;
    assign loc_req.pos   = i_in.spiral_position - POS_W'(1);

    spok_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (loc_req),
        .o_rsp   (loc_rsp)
    );

    // Read the located element as soon as the walker reports it.
    assign ram_re    = (r_state == S_WALK) && loc_rsp.done;
    assign ram_raddr = {loc_rsp.row, loc_rsp.col};

    spok_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.element_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_oor       = r_oor;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.command == CMD_QUERY) begin
                    n_err   = pos_bad;
                    n_state = pos_bad ? S_LOAD : S_WALK;
                end
            end
            S_WALK: begin
                if (loc_rsp.done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_err ? '0 : ram_rdata;
                    n_oor       = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err   <= n_err;
        r_found <= n_found;
        r_oor   <= n_oor;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found_value  = r_found;
    assign o_out.out_of_range = r_oor;

`ifndef SYNTHESIS
    // The walker only reports while a query is being walked.
    a_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        loc_rsp.done |-> r_state == S_WALK)
        else $error("walker reported outside a query walk");

    // An out-of-range result always carries a zero value.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_of_range |-> o_out.found_value == '0)
        else $error("out-of-range result with non-zero value");

    // An accepted query blocks further requests in the next cycle.
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.command == CMD_QUERY |=> !i_in.ready)
        else $error("request accepted while a query was in flight");

    // A write request never disturbs the sequencer.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.command == CMD_WRITE |=> r_state == S_IDLE)
        else $error("write request left the idle state");
`endif

endmodule
